/* src/rlp_pkg.sv */
package rlp_pkg;

    // Field widths
    localparam int SAMPLE_W   = 10;
    localparam int CH_W       = 3;
    localparam int PERIOD_W   = 8;
    localparam int PCT_W      = 7;

    // Run sum holds up to 64 full-scale samples
    localparam int MAX_SAMPLE_COUNT = 64;
    localparam int SUM_W      = SAMPLE_W + $clog2(MAX_SAMPLE_COUNT);

    // Divider width covers the run sum and 100 times a full-scale average
    localparam int PCT_FULL   = 100;
    localparam int DIV_W      = SAMPLE_W + 7;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAIN_CH   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CALIB_CH  = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RST   = 8'd100;
    localparam logic [CH_W-1:0]     RAIN_CH_RST  = 3'd0;
    localparam logic [CH_W-1:0]     CALIB_CH_RST = 3'd1;

    // Parameter defaults
    localparam int SAMPLE_COUNT_DEF      = 8;
    localparam int INITIAL_MAX_LEVEL_DEF = 1023;
    localparam int ADC_BITS_DEF          = 10;

    // One classified sample travelling from front to back
    typedef struct packed {
        logic [CH_W-1:0]  next_channel;
        logic             run_done;
        logic             was_calib;
        logic [SUM_W-1:0] sum;
    } t_item;

    // One finished result
    typedef struct packed {
        logic [CH_W-1:0]  next_channel;
        logic             run_done;
        logic             was_calib;
        logic             result_valid;
        logic [PCT_W-1:0] rain_percent;
    } t_result;

    // Mask of the ADC bits that are used within a sample field
    function automatic logic [SAMPLE_W-1:0] sample_mask(input int adc_bits);
        logic [SAMPLE_W-1:0] m;
        begin
            if (adc_bits >= SAMPLE_W) begin
                m = '1;
            end else begin
                m = SAMPLE_W'((1 << adc_bits) - 1);
            end
            return m;
        end
    endfunction

endpackage

/* src/rain_level_percent_calibrated_unit.sv */
// Path: a sample inside a run goes through the queue and the output register to the result
// ports; the sample that ends a run steps the back part through average, check, a serial
// divide (rain runs only, not calibration runs or saturated percentages) and write-back.
// Throughput: one sample per cycle while the queue has room; a run end holds the back part
// (a serial divide on a rain run) while a 4-entry queue lets the front keep taking samples.
// Reset (i_rst_n low, synchronous) empties both queues and restores registers.
module rain_level_percent_calibrated_unit #(
    parameter int SAMPLE_COUNT      = rlp_pkg::SAMPLE_COUNT_DEF,
    parameter int INITIAL_MAX_LEVEL = rlp_pkg::INITIAL_MAX_LEVEL_DEF,
    parameter int ADC_BITS          = rlp_pkg::ADC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rlp_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [rlp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [rlp_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                            empty,
    input  logic                            pop,
    output logic [rlp_pkg::CH_W-1:0]        o_next_channel,
    output logic                            o_run_done,
    output logic                            o_was_calibration,
    output logic                            o_result_valid,
    output logic [rlp_pkg::PCT_W-1:0]       o_rain_percent
);

    logic [rlp_pkg::PERIOD_W-1:0] r_period;
    logic [rlp_pkg::CH_W-1:0]     r_rain_ch, r_calib_ch;

    logic              q_push, q_full, q_pop, q_empty;
    rlp_pkg::t_item    q_in, q_out;
    rlp_pkg::t_result  result;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= rlp_pkg::PERIOD_RST;
            r_rain_ch  <= rlp_pkg::RAIN_CH_RST;
            r_calib_ch <= rlp_pkg::CALIB_CH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rlp_pkg::CFG_PERIOD:   r_period   <= i_cfg_data;
                rlp_pkg::CFG_RAIN_CH:  r_rain_ch  <= i_cfg_data[rlp_pkg::CH_W-1:0];
                rlp_pkg::CFG_CALIB_CH: r_calib_ch <= i_cfg_data[rlp_pkg::CH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rlp_front #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .ADC_BITS     (ADC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_sample   (i_sample),
        .i_period   (r_period),
        .i_rain_ch  (r_rain_ch),
        .i_calib_ch (r_calib_ch),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_item   (q_in)
    );

    rlp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_out)
    );

    rlp_back #(
        .SAMPLE_COUNT      (SAMPLE_COUNT),
        .INITIAL_MAX_LEVEL (INITIAL_MAX_LEVEL),
        .ADC_BITS          (ADC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_item  (q_out),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (result)
    );

    assign full              = q_full;
    assign o_next_channel    = result.next_channel;
    assign o_run_done        = result.run_done;
    assign o_was_calibration = result.was_calib;
    assign o_result_valid    = result.result_valid;
    assign o_rain_percent    = result.rain_percent;

endmodule

/* src/rlp_front.sv */
module rlp_front #(
    parameter int SAMPLE_COUNT = rlp_pkg::SAMPLE_COUNT_DEF,
    parameter int ADC_BITS     = rlp_pkg::ADC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [rlp_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [rlp_pkg::PERIOD_W-1:0]  i_period,
    input  logic [rlp_pkg::CH_W-1:0]      i_rain_ch,
    input  logic [rlp_pkg::CH_W-1:0]      i_calib_ch,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output rlp_pkg::t_item                o_q_item
);

    localparam int IDX_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam logic [rlp_pkg::SAMPLE_W-1:0] MASK = rlp_pkg::sample_mask(ADC_BITS);

    logic [IDX_W-1:0]               r_idx, n_idx;
    logic [rlp_pkg::PERIOD_W-1:0]   r_run, n_run;
    logic [rlp_pkg::SUM_W-1:0]      r_sum, n_sum;

    logic                           accept;
    logic                           last;
    logic [rlp_pkg::SUM_W-1:0]      sum_new;
    logic [rlp_pkg::PERIOD_W-1:0]   period_eff;
    logic [rlp_pkg::PERIOD_W:0]     run_inc;
    logic [rlp_pkg::PERIOD_W-1:0]   run_after;

    assign accept = i_push && !i_q_full;
    assign last   = (r_idx == IDX_W'(SAMPLE_COUNT - 1));

    // Accumulate the run and advance the run counter at the end of a run
    always_comb begin
        sum_new    = r_sum + rlp_pkg::SUM_W'(i_sample & MASK);
        period_eff = (i_period == '0) ? rlp_pkg::PERIOD_W'(1) : i_period;
        run_inc    = {1'b0, r_run} + (rlp_pkg::PERIOD_W + 1)'(1);
        if (last) begin
            run_after = (run_inc >= {1'b0, period_eff}) ? '0 : run_inc[rlp_pkg::PERIOD_W-1:0];
        end else begin
            run_after = r_run;
        end

        n_idx = r_idx;
        n_run = r_run;
        n_sum = r_sum;
        if (accept) begin
            n_run = run_after;
            if (last) begin
                n_idx = '0;
                n_sum = '0;
            end else begin
                n_idx = r_idx + IDX_W'(1);
                n_sum = sum_new;
            end
        end
    end

    // Classify the sample for the back part
    always_comb begin
        o_q_push              = accept;
        o_q_item.next_channel = (run_after == '0) ? i_calib_ch : i_rain_ch;
        o_q_item.run_done     = last;
        o_q_item.was_calib    = last && (r_run == '0);
        o_q_item.sum          = sum_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_run <= '0;
            r_sum <= '0;
        end else begin
            r_idx <= n_idx;
            r_run <= n_run;
            r_sum <= n_sum;
        end
    end

endmodule

/* src/rlp_fifo.sv */
module rlp_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rlp_pkg::t_item  i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output rlp_pkg::t_item  o_item
);

    localparam int PTR_W = $clog2(rlp_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(rlp_pkg::FIFO_DEPTH + 1);

    rlp_pkg::t_item   r_mem [rlp_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(rlp_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store the transfer
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Advance the pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(rlp_pkg::FIFO_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(rlp_pkg::FIFO_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

/* src/rlp_div.sv */
module rlp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rlp_pkg::DIV_W-1:0]  i_dividend,
    input  logic [rlp_pkg::DIV_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [rlp_pkg::DIV_W-1:0]  o_quotient
);

    localparam int W     = rlp_pkg::DIV_W;
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     r_quo, r_dsr;
    logic [W:0]       r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [W:0]       shifted;
    logic             ge;

    // One quotient bit per cycle, restoring
    assign shifted    = {r_rem[W-1:0], r_quo[W-1]};
    assign ge         = (shifted >= {1'b0, r_dsr});
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], ge};
            r_rem <= ge ? (shifted - {1'b0, r_dsr}) : shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

/* src/rlp_back.sv */
module rlp_back #(
    parameter int SAMPLE_COUNT      = rlp_pkg::SAMPLE_COUNT_DEF,
    parameter int INITIAL_MAX_LEVEL = rlp_pkg::INITIAL_MAX_LEVEL_DEF,
    parameter int ADC_BITS          = rlp_pkg::ADC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  rlp_pkg::t_item    i_q_item,
    output logic              o_q_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output rlp_pkg::t_result  o_result
);

    localparam int W  = rlp_pkg::DIV_W;
    localparam int SW = rlp_pkg::SAMPLE_W;
    localparam logic [SW-1:0] FS_RST =
        SW'(INITIAL_MAX_LEVEL) & rlp_pkg::sample_mask(ADC_BITS);

    // Average by reciprocal multiplication, exact for every run sum that fits SUM_W
    localparam int AVG_SHIFT =
        rlp_pkg::SUM_W + ((SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 0);
    localparam int AVG_RECIP = ((1 << AVG_SHIFT) + SAMPLE_COUNT - 1) / SAMPLE_COUNT;
    localparam int PROD_W    = 2 * rlp_pkg::SUM_W + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_AVG  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_PCT  = 3'd3;
    localparam logic [2:0] ST_WB   = 3'd4;

    logic [2:0]                  r_state, n_state;
    rlp_pkg::t_item              r_item, n_item;
    logic [SW-1:0]               r_fs, n_fs;
    logic [SW-1:0]               r_avg, n_avg;
    logic                        r_have, n_have;
    logic [rlp_pkg::PCT_W-1:0]   r_pct, n_pct;
    rlp_pkg::t_result            r_out, n_out;
    logic                        r_out_valid;
    logic                        load;
    logic                        out_free;

    logic                        div_start;
    logic [W-1:0]                div_dividend, div_divisor;
    logic                        div_done;
    logic [W-1:0]                div_quo;
    logic [PROD_W-1:0]           avg_prod;
    logic [SW-1:0]               avg;

    assign out_free = !r_out_valid || i_pop;
    assign avg_prod = PROD_W'(r_item.sum) * PROD_W'(AVG_RECIP);
    assign avg      = avg_prod[AVG_SHIFT +: SW];
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    rlp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Pass run samples to the output; sequence a finished run through average and calibration or percentage
    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_fs         = r_fs;
        n_avg        = r_avg;
        n_have       = r_have;
        n_pct        = r_pct;
        n_out        = r_out;
        load         = 1'b0;
        o_q_pop      = 1'b0;
        div_start    = 1'b0;
        div_dividend = W'(rlp_pkg::PCT_FULL) * W'(r_avg);
        div_divisor  = W'(r_fs);
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_item.run_done) begin
                        o_q_pop   = 1'b1;
                        n_item    = i_q_item;
                        n_state   = ST_AVG;
                    end else if (out_free) begin
                        o_q_pop                = 1'b1;
                        load                   = 1'b1;
                        n_out.next_channel     = i_q_item.next_channel;
                        n_out.run_done         = 1'b0;
                        n_out.was_calib        = 1'b0;
                        n_out.result_valid     = r_have;
                        n_out.rain_percent     = r_pct;
                    end
                end
            end
            ST_AVG: begin
                n_avg   = avg;
                n_state = ST_CHK;
            end
            ST_CHK: begin
                if (r_item.was_calib) begin
                    n_fs    = r_avg;
                    n_state = ST_WB;
                end else if ((r_fs == '0) || (r_avg > r_fs)) begin
                    n_pct   = '0;
                    n_have  = 1'b1;
                    n_state = ST_WB;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_PCT;
                end
            end
            ST_PCT: begin
                if (div_done) begin
                    n_pct   = rlp_pkg::PCT_W'(rlp_pkg::PCT_FULL) - div_quo[rlp_pkg::PCT_W-1:0];
                    n_have  = 1'b1;
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                if (out_free) begin
                    load               = 1'b1;
                    n_out.next_channel = r_item.next_channel;
                    n_out.run_done     = 1'b1;
                    n_out.was_calib    = r_item.was_calib;
                    n_out.result_valid = r_have;
                    n_out.rain_percent = r_pct;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_avg  <= n_avg;
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fs        <= FS_RST;
            r_have      <= 1'b0;
            r_pct       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fs        <= n_fs;
            r_have      <= n_have;
            r_pct       <= n_pct;
            r_out_valid <= load || (r_out_valid && !i_pop);
        end
    end

endmodule

/* src/rlp_checker.sv */
module rlp_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       full,
    input logic                       empty,
    input logic                       pop,
    input logic                       o_was_calibration,
    input logic                       o_run_done,
    input logic                       o_result_valid,
    input logic [rlp_pkg::PCT_W-1:0]  o_rain_percent
);

    // Reset leaves both sides with nothing queued
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    // A calibration flag only comes with a finished run
    a_calib_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_was_calibration) |-> o_run_done)
        else $error("calibration flag without run end");

    // Percentage stays in range and reads zero before the first result
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_rain_percent <= rlp_pkg::PCT_W'(rlp_pkg::PCT_FULL))
                    && (o_result_valid || (o_rain_percent == '0))))
        else $error("rain percentage out of range");

    // Once a percentage exists it never disappears
    a_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_valid && pop) ##1 !empty |-> o_result_valid)
        else $error("result_valid dropped");

    // A waiting result holds until it is taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_rain_percent)))
        else $error("waiting result changed");

endmodule

bind rain_level_percent_calibrated_unit rlp_checker u_rlp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .full              (full),
    .empty             (empty),
    .pop               (pop),
    .o_was_calibration (o_was_calibration),
    .o_run_done        (o_run_done),
    .o_result_valid    (o_result_valid),
    .o_rain_percent    (o_rain_percent)
);

/* bench/rain_percent_checker.sv */
module rain_percent_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rlp_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [rlp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_push,
    input  logic                           i_full,
    input  logic [rlp_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  logic [rlp_pkg::CH_W-1:0]       i_next_channel,
    input  logic                           i_run_done,
    input  logic                           i_was_calibration,
    input  logic                           i_result_valid,
    input  logic [rlp_pkg::PCT_W-1:0]      i_rain_percent,
    output int                             o_mismatch_count,
    output int                             o_pending
);

    localparam int RUN_LEN     = rlp_pkg::SAMPLE_COUNT_DEF;

    // Shadow registers
    logic [rlp_pkg::PERIOD_W-1:0] period_reg;
    logic [rlp_pkg::CH_W-1:0]     rain_ch_reg;
    logic [rlp_pkg::CH_W-1:0]     calib_ch_reg;

    // Shadow sensor state
    logic [rlp_pkg::SAMPLE_W-1:0] full_scale;
    int                           run_idx;
    int                           samples_in_run;
    int                           run_sum;
    logic [rlp_pkg::PCT_W-1:0]    latest_pct;
    logic                         have_pct;

    rlp_pkg::t_result expected_readings[$];
    int               mismatch_count = 0;

    assign o_mismatch_count = mismatch_count;

    // Coverage percentage; saturate to 0 on zero full scale or overrange average
    function automatic int coverage_percent(input int avg, input int fs);
        if (fs == 0 || avg > fs) begin
            return 0;
        end
        return rlp_pkg::PCT_FULL - (rlp_pkg::PCT_FULL * avg) / fs;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Advance the shadow state by one sample and queue the reading it yields
    task automatic predict_reading(input logic [rlp_pkg::SAMPLE_W-1:0] s);
        rlp_pkg::t_result r;
        int               avg;
        int               span;
        int               nxt;
        r = '0;
        run_sum = run_sum + s;
        samples_in_run++;
        if (samples_in_run >= RUN_LEN) begin
            avg = run_sum / RUN_LEN;
            r.run_done = 1'b1;
            if (run_idx == 0) begin
                full_scale  = avg[rlp_pkg::SAMPLE_W-1:0];
                r.was_calib = 1'b1;
            end else begin
                latest_pct = rlp_pkg::PCT_W'(coverage_percent(avg, full_scale));
                have_pct   = 1'b1;
            end
            // A period of zero behaves as one; an index past the period wraps
            span    = (period_reg == '0) ? 1 : period_reg;
            nxt     = run_idx + 1;
            run_idx = (nxt >= span) ? 0 : nxt;
            run_sum = 0;
            samples_in_run = 0;
        end
        r.next_channel = (run_idx == 0) ? calib_ch_reg : rain_ch_reg;
        r.result_valid = have_pct;
        r.rain_percent = have_pct ? latest_pct : '0;
        expected_readings.push_back(r);
    endtask

    // Compare one result transfer with the oldest queued reading
    task automatic check_reading();
        rlp_pkg::t_result want;
        if (expected_readings.size() == 0) begin
            report_mismatch("result transfer with none pending, channel", i_next_channel, 0);
            return;
        end
        want = expected_readings.pop_front();
        if (i_next_channel !== want.next_channel) begin
            report_mismatch("next_channel", i_next_channel, want.next_channel);
        end
        if (i_run_done !== want.run_done) begin
            report_mismatch("run_done", i_run_done, want.run_done);
        end
        if (i_was_calibration !== want.was_calib) begin
            report_mismatch("was_calibration", i_was_calibration, want.was_calib);
        end
        if (i_result_valid !== want.result_valid) begin
            report_mismatch("result_valid", i_result_valid, want.result_valid);
        end
        if (i_rain_percent !== want.rain_percent) begin
            report_mismatch("rain_percent", i_rain_percent, want.rain_percent);
        end
    endtask

    // Track register writes and both channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            period_reg     = rlp_pkg::PERIOD_RST;
            rain_ch_reg    = rlp_pkg::RAIN_CH_RST;
            calib_ch_reg   = rlp_pkg::CALIB_CH_RST;
            full_scale     = rlp_pkg::SAMPLE_W'(rlp_pkg::INITIAL_MAX_LEVEL_DEF);
            run_idx        = 0;
            samples_in_run = 0;
            run_sum        = 0;
            latest_pct     = '0;
            have_pct       = 1'b0;
            expected_readings.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    rlp_pkg::CFG_PERIOD:
                        period_reg   = i_cfg_data[rlp_pkg::PERIOD_W-1:0];
                    rlp_pkg::CFG_RAIN_CH:
                        rain_ch_reg  = i_cfg_data[rlp_pkg::CH_W-1:0];
                    rlp_pkg::CFG_CALIB_CH:
                        calib_ch_reg = i_cfg_data[rlp_pkg::CH_W-1:0];
                    // drop writes to the unused index
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                check_reading();
            end
            if (i_push && !i_full) begin
                predict_reading(i_sample);
            end
        end
        o_pending <= expected_readings.size();
    end

endmodule

/* bench/rain_level_percent_calibrated_unit_tb.sv */
module rain_level_percent_calibrated_unit_tb;

    localparam logic [rlp_pkg::CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;
    localparam int RUN_LEN        = rlp_pkg::SAMPLE_COUNT_DEF;
    localparam int PHASES         = 6;
    localparam int RUNS_PER_PHASE = 24;
    localparam int STALL_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 2 * rlp_pkg::DIV_W + 25;

    // Content of one run of samples
    typedef enum int {
        RUN_UNIFORM,
        RUN_ZERO,
        RUN_FULL,
        RUN_LOW,
        RUN_HIGH,
        RUN_LEVEL
    } t_run_shape;

    logic                           i_clk;
    logic                           i_rst_n    = 1'b0;
    logic                           cfg_we     = 1'b0;
    logic [rlp_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
    logic [rlp_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
    logic                           push       = 1'b0;
    logic [rlp_pkg::SAMPLE_W-1:0]   sample     = '0;
    logic                           pop        = 1'b0;
    logic                           full;
    logic                           empty;
    logic [rlp_pkg::CH_W-1:0]       next_channel;
    logic                           run_done;
    logic                           was_calibration;
    logic                           result_valid;
    logic [rlp_pkg::PCT_W-1:0]      rain_percent;

    int                             mismatch_count;
    int                             pending;
    int                             tx_idle_pct = 27;
    int                             rx_idle_pct = 45;
    int                             stalled_cycles = 0;
    logic [rlp_pkg::SAMPLE_W-1:0]   held_level = 10'd512;

    rain_level_percent_calibrated_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_addr        (cfg_addr),
        .i_cfg_data        (cfg_data),
        .push              (push),
        .full              (full),
        .i_sample          (sample),
        .empty             (empty),
        .pop               (pop),
        .o_next_channel    (next_channel),
        .o_run_done        (run_done),
        .o_was_calibration (was_calibration),
        .o_result_valid    (result_valid),
        .o_rain_percent    (rain_percent)
    );

    rain_percent_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_addr        (cfg_addr),
        .i_cfg_data        (cfg_data),
        .i_push            (push),
        .i_full            (full),
        .i_sample          (sample),
        .i_empty           (empty),
        .i_pop             (pop),
        .i_next_channel    (next_channel),
        .i_run_done        (run_done),
        .i_was_calibration (was_calibration),
        .i_result_valid    (result_valid),
        .i_rain_percent    (rain_percent),
        .o_mismatch_count  (mismatch_count),
        .o_pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    // End the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || cfg_we) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // Offer one sample after a random gap and hold it until the transfer
    task automatic push_sample(input logic [rlp_pkg::SAMPLE_W-1:0] v);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        sample <= v;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
    endtask

    // Hold the sender until every pending reading has been delivered
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write all three registers plus the unused index, which must be ignored
    task automatic write_settings(input logic [7:0] period, input logic [7:0] rain,
                                  input logic [7:0] calib);
        cfg_we   <= 1'b1;
        cfg_addr <= rlp_pkg::CFG_PERIOD;
        cfg_data <= period;
        @(posedge i_clk);
        cfg_addr <= rlp_pkg::CFG_RAIN_CH;
        cfg_data <= rain;
        @(posedge i_clk);
        cfg_addr <= rlp_pkg::CFG_CALIB_CH;
        cfg_data <= calib;
        @(posedge i_clk);
        cfg_addr <= CFG_SPARE;
        cfg_data <= rlp_pkg::CFG_DATA_W'($urandom);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic send_run(input t_run_shape shape);
        logic [rlp_pkg::SAMPLE_W-1:0] v;
        int                           k;
        // Reuse a level across runs so averages can match full scale exactly
        if (shape == RUN_LEVEL && $urandom_range(1) == 0) begin
            held_level = rlp_pkg::SAMPLE_W'($urandom);
        end
        for (k = 0; k < RUN_LEN; k++) begin
            case (shape)
                RUN_ZERO: v = '0;
                RUN_FULL: v = '1;
                RUN_LOW:  v = rlp_pkg::SAMPLE_W'($urandom_range(63));
                RUN_HIGH: v = rlp_pkg::SAMPLE_W'($urandom_range(1023, 960));
                RUN_LEVEL: v = held_level;
                default:  v = rlp_pkg::SAMPLE_W'($urandom);
            endcase
            push_sample(v);
        end
    endtask

    initial begin
        int ph;
        int r;
        int k;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: calibration run of alternating extremes and bit patterns
        for (k = 0; k < RUN_LEN; k++) begin
            if (k < RUN_LEN / 2) begin
                push_sample((k % 2 == 0) ? 10'h3FF : 10'h000);
            end else begin
                push_sample((k % 2 == 0) ? 10'h2AA : 10'h155);
            end
        end
        // Dry electrode gives full coverage, then an overrange average saturates
        send_run(RUN_ZERO);
        send_run(RUN_FULL);

        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: write_settings(8'd0, 8'd7, 8'd0);
                1: write_settings(8'd1, 8'hF8, 8'hFF);
                2: write_settings(8'd255, 8'($urandom), 8'($urandom));
                3: write_settings(8'd2, 8'($urandom), 8'($urandom));
                4: write_settings(8'd3, 8'($urandom), 8'($urandom));
                default: write_settings(8'($urandom_range(20, 4)), 8'($urandom),
                                        8'($urandom));
            endcase
            if (ph < 2) begin
                tx_idle_pct = 27;
                rx_idle_pct = 45;
            end else if (ph < 4) begin
                tx_idle_pct = 45;
                rx_idle_pct = 27;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (r = 0; r < RUNS_PER_PHASE; r++) begin
                if (r == RUNS_PER_PHASE / 2 && ph % 2 == 1) begin
                    drain();
                end
                send_run(t_run_shape'($urandom_range(RUN_LEVEL)));
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/rlp_pkg.sv
src/rlp_front.sv
src/rlp_fifo.sv
src/rlp_div.sv
src/rlp_back.sv
src/rain_level_percent_calibrated_unit.sv
src/rlp_checker.sv
bench/rain_percent_checker.sv
bench/rain_level_percent_calibrated_unit_tb.sv
